// File: rtl/sampson_error_squared_top_assert.svh
// assertion macros for the sampson error block checker
`ifndef SAMPSON_ERROR_SQUARED_TOP_ASSERT_SVH
`define SAMPSON_ERROR_SQUARED_TOP_ASSERT_SVH

// condition implies consequence in the same cycle, outside reset
`define SSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle, outside reset
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// reset implies consequence in the next cycle
`define SSE_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// File: rtl/sse_pkg.sv
// shared constants and widths for the sampson error block
`default_nettype none
package sse_pkg;

  // configuration port
  localparam int CFG_DATA_W = 60;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

  // gradient terms carry 16 fraction bits, their width does not depend on the formats
  localparam int GRAD_FRAC = 16;
  localparam int G_W       = 25;
  localparam int A_W       = 32;
  localparam int NUM_W     = 2 * A_W;
  localparam int DEN_W     = 2 * G_W + 2;

  // result format
  localparam int QUOT_W    = 32;
  localparam int OUT_FRAC  = 16;

  // queue between front and back
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;

endpackage
`default_nettype wire

// File: rtl/sse_front.sv
// front pipeline: matrix products, gradients, algebraic error, numerator and denominator
`default_nettype none
module sse_front #(
  parameter int COEF_WIDTH  = 20,
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [sse_pkg::CFG_DATA_W-1:0]     row0,
  input  wire logic [sse_pkg::CFG_DATA_W-1:0]     row1,
  input  wire logic [sse_pkg::CFG_DATA_W-1:0]     row2,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]      in_first_x,
  input  wire logic signed [COORD_WIDTH-1:0]      in_first_y,
  input  wire logic signed [COORD_WIDTH-1:0]      in_second_x,
  input  wire logic signed [COORD_WIDTH-1:0]      in_second_y,
  output logic                                    f_valid,
  input  wire logic                               f_ready,
  output logic [sse_pkg::NUM_W-1:0]               f_num,
  output logic [sse_pkg::DEN_W-1:0]               f_den
);
  import sse_pkg::*;

  localparam int CF     = COEF_WIDTH - 2;
  localparam int PF     = COORD_WIDTH - 4;
  localparam int GSHIFT = CF + PF - GRAD_FRAC;
  localparam int P_W    = COEF_WIDTH + COORD_WIDTH;
  localparam int S_W    = COEF_WIDTH + COORD_WIDTH + 3;
  localparam int AP_W   = COORD_WIDTH + G_W;
  localparam int AS_W   = COORD_WIDTH + G_W + 3;
  localparam int ROW_W  = (3 * COEF_WIDTH > CFG_DATA_W) ? 3 * COEF_WIDTH : CFG_DATA_W;
  localparam logic signed [S_W-1:0]  G_RND = S_W'(1) << (GSHIFT - 1);
  localparam logic signed [AS_W-1:0] A_RND = AS_W'(1) << (PF - 1);

  logic [ROW_W-1:0] rw [3];
  logic signed [COEF_WIDTH-1:0] e [3][3];

  logic [4:0] v_r;
  logic       en;

  // stage 1 products
  logic signed [P_W-1:0]        pg_r [3][2];
  logic signed [COEF_WIDTH-1:0] cg_r [3];
  logic signed [P_W-1:0]        ph_r [2][2];
  logic signed [COEF_WIDTH-1:0] ch_r [2];
  logic signed [COORD_WIDTH-1:0] x2_r, y2_r, x2b_r, y2b_r;

  // stage 2 gradients
  logic signed [S_W-1:0] sg [3];
  logic signed [S_W-1:0] sh [2];
  logic signed [G_W-1:0] g_r [3];
  logic signed [G_W-1:0] h_r [2];

  // stage 3 products
  logic signed [AP_W-1:0]  ax_r, ay_r;
  logic signed [G_W-1:0]   g2_r;
  logic signed [2*G_W-1:0] sq_r [4];

  // stage 4 error and denominator
  logic signed [AS_W-1:0]  as_sum;
  logic signed [A_W-1:0]   a_r;
  logic [DEN_W-1:0]        den_nxt;
  logic [DEN_W-1:0]        den4_r, den5_r;
  logic [NUM_W-1:0]        num_r;

  // unpack coefficients, bits above the register width read as zero
  always_comb begin
    rw[0] = ROW_W'(row0);
    rw[1] = ROW_W'(row1);
    rw[2] = ROW_W'(row2);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        e[r][c] = rw[r][c*COEF_WIDTH +: COEF_WIDTH];
      end
    end
  end

  // whole pipeline moves when its last stage is empty or drained
  assign en       = !v_r[4] || f_ready;
  assign in_ready = en;
  assign f_valid  = v_r[4];
  assign f_num    = num_r;
  assign f_den    = den5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // stage 1: coefficient times coordinate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pg_r[r][0] <= e[r][0] * in_first_x;
        pg_r[r][1] <= e[r][1] * in_first_y;
        cg_r[r]    <= e[r][2];
      end
      for (int c = 0; c < 2; c++) begin
        ph_r[c][0] <= e[0][c] * in_second_x;
        ph_r[c][1] <= e[1][c] * in_second_y;
        ch_r[c]    <= e[2][c];
      end
      x2_r <= in_second_x;
      y2_r <= in_second_y;
    end
  end

  // stage 2: three-term sums rounded to 16 fraction bits
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sg[r] = S_W'(pg_r[r][0]) + S_W'(pg_r[r][1]) + (S_W'(cg_r[r]) <<< PF) + G_RND;
    end
    for (int c = 0; c < 2; c++) begin
      sh[c] = S_W'(ph_r[c][0]) + S_W'(ph_r[c][1]) + (S_W'(ch_r[c]) <<< PF) + G_RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        g_r[r] <= G_W'(sg[r] >>> GSHIFT);
      end
      for (int c = 0; c < 2; c++) begin
        h_r[c] <= G_W'(sh[c] >>> GSHIFT);
      end
      x2b_r <= x2_r;
      y2b_r <= y2_r;
    end
  end

  // stage 3: error products and gradient squares
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= x2b_r * g_r[0];
      ay_r    <= y2b_r * g_r[1];
      g2_r    <= g_r[2];
      sq_r[0] <= g_r[0] * g_r[0];
      sq_r[1] <= g_r[1] * g_r[1];
      sq_r[2] <= h_r[0] * h_r[0];
      sq_r[3] <= h_r[1] * h_r[1];
    end
  end

  // stage 4: algebraic error and gradient sum
  always_comb begin
    as_sum  = AS_W'(ax_r) + AS_W'(ay_r) + (AS_W'(g2_r) <<< PF) + A_RND;
    den_nxt = DEN_W'($unsigned(sq_r[0])) + DEN_W'($unsigned(sq_r[1]))
            + DEN_W'($unsigned(sq_r[2])) + DEN_W'($unsigned(sq_r[3]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= A_W'(as_sum >>> PF);
      den4_r <= den_nxt;
    end
  end

  // stage 5: squared error
  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= a_r * a_r;
      den5_r <= den4_r;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sse_fifo.sv
// short queue between front and back pipelines
`default_nettype none
module sse_fifo #(
  parameter int DATA_W = 116
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   empty
);
  import sse_pkg::*;

  logic [DATA_W-1:0]  mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign full     = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/sse_back.sv
// back pipeline: special cases and one quotient bit per stage
`default_nettype none
module sse_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  input  wire logic [sse_pkg::NUM_W-1:0]    q_num,
  input  wire logic [sse_pkg::DEN_W-1:0]    q_den,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sse_pkg::QUOT_W-1:0]        out_error_squared,
  output logic                              out_saturated,
  output logic                              out_zero_denominator
);
  import sse_pkg::*;

  localparam int NS    = QUOT_W;
  localparam int R_W   = DEN_W + 1;
  localparam int CMP_W = (NUM_W > DEN_W + OUT_FRAC) ? NUM_W : DEN_W + OUT_FRAC;

  logic              v_r    [NS+1];
  logic [R_W-1:0]    rem_r  [NS+1];
  logic [QUOT_W-1:0] qd_r   [NS+1];
  logic [DEN_W-1:0]  den_r  [NS+1];
  logic              sat_r  [NS+1];
  logic              zero_r [NS+1];

  logic              en;
  logic              zero0, sat0;
  logic [R_W-1:0]    t      [NS];
  logic              bit_q  [NS];

  assign en    = !v_r[NS] || out_ready;
  assign q_pop = en && !q_empty;

  // classify: zero gradient sum, or quotient at or above 65536
  always_comb begin
    zero0 = (q_den == '0);
    sat0  = !zero0 && (CMP_W'(q_num) >= (CMP_W'(q_den) << OUT_FRAC));
  end

  // one restoring division step per stage
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      t[i]     = {rem_r[i][R_W-2:0], qd_r[i][QUOT_W-1]};
      bit_q[i] = (t[i] >= {1'b0, den_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= !q_empty;
      for (int i = 1; i <= NS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // load: high part of the dividend seeds the remainder
      rem_r[0]  <= (zero0 || sat0) ? '0 : R_W'(q_num >> OUT_FRAC);
      qd_r[0]   <= {q_num[OUT_FRAC-1:0], {(QUOT_W-OUT_FRAC){1'b0}}};
      den_r[0]  <= q_den;
      sat_r[0]  <= sat0;
      zero_r[0] <= zero0;
      for (int i = 0; i < NS; i++) begin
        rem_r[i+1]  <= bit_q[i] ? (t[i] - {1'b0, den_r[i]}) : t[i];
        qd_r[i+1]   <= {qd_r[i][QUOT_W-2:0], bit_q[i]};
        den_r[i+1]  <= den_r[i];
        sat_r[i+1]  <= sat_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // result from the last stage
  assign out_valid            = v_r[NS];
  assign out_saturated        = sat_r[NS];
  assign out_zero_denominator = zero_r[NS];
  assign out_error_squared    = (sat_r[NS] || zero_r[NS]) ? '1 : qd_r[NS];

endmodule
`default_nettype wire

// File: rtl/sampson_error_squared_top.sv
// Squared Sampson error of a point correspondence against a 3x3 matrix held in
// three row registers. One correspondence is taken per clock and one result is
// given per clock unless a low out_ready or a full queue stalls them. An item
// passes 5 front stages of products and sums, the 4-entry queue, a load stage
// and 32 stages of a pipelined restoring divider, one quotient bit each. The
// user must write matrix rows only while no item is in flight; not enforced here.
`default_nettype none
module sampson_error_squared_top #(
  parameter int COEF_WIDTH  = 20,
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [sse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sse_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]     in_first_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_first_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_second_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_second_y,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sse_pkg::QUOT_W-1:0]             out_error_squared,
  output logic                                   out_saturated,
  output logic                                   out_zero_denominator
);
  import sse_pkg::*;

  localparam int QW = NUM_W + DEN_W;

  logic [CFG_DATA_W-1:0] row_r [3];
  logic                  f_valid, q_full, q_empty, q_pop;
  logic [NUM_W-1:0]      f_num;
  logic [DEN_W-1:0]      f_den;
  logic [QW-1:0]         q_out;

  // matrix row registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= '0;
      row_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW0: row_r[0] <= cfg_data;
        REG_ROW1: row_r[1] <= cfg_data;
        REG_ROW2: row_r[2] <= cfg_data;
        default:  ;
      endcase
    end
  end

  sse_front #(
    .COEF_WIDTH  (COEF_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .row0        (row_r[0]),
    .row1        (row_r[1]),
    .row2        (row_r[2]),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_first_x  (in_first_x),
    .in_first_y  (in_first_y),
    .in_second_x (in_second_x),
    .in_second_y (in_second_y),
    .f_valid     (f_valid),
    .f_ready     (!q_full),
    .f_num       (f_num),
    .f_den       (f_den)
  );

  sse_fifo #(
    .DATA_W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid && !q_full),
    .push_data ({f_num, f_den}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sse_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_pop                (q_pop),
    .q_num                (q_out[QW-1:DEN_W]),
    .q_den                (q_out[DEN_W-1:0]),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_error_squared    (out_error_squared),
    .out_saturated        (out_saturated),
    .out_zero_denominator (out_zero_denominator)
  );

endmodule
`default_nettype wire

// File: rtl/sse_checker.sv
// port-level checker for the sampson error block and its bind
`default_nettype none
`include "sampson_error_squared_top_assert.svh"
module sse_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [sse_pkg::QUOT_W-1:0]  out_error_squared,
  input wire logic                        out_saturated,
  input wire logic                        out_zero_denominator
);
  import sse_pkg::*;

  // no result right after reset
  `SSE_ASSERT_RST(a_rst_empty, !out_valid, "result valid after reset")

  // zero denominator gives the maximum and no saturation flag
  `SSE_ASSERT_NOW(a_zero_max, out_valid && out_zero_denominator, out_error_squared == '1 && !out_saturated, "zero denominator result wrong")

  // saturation gives the maximum
  `SSE_ASSERT_NOW(a_sat_max, out_valid && out_saturated, out_error_squared == '1, "saturated result not maximum")

  // stalled result holds
  `SSE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_error_squared), "stalled result changed")

endmodule

bind sampson_error_squared_top sse_checker u_sse_checker (.*);
`default_nettype wire
